// ===== src/sgc_pkg.sv =====
// ----------------------------------------------------------------------------
// sgc_pkg: shared definitions for the Sobel gradient clamp core
// Register indexes, widths, limits and the item type that travels through
// the queue between the front and back parts.
// ----------------------------------------------------------------------------
package sgc_pkg;

   // Field widths of the ports.
   localparam int PIXEL_W   = 8;
   localparam int COORD_W   = 10;
   localparam int SIZE_W    = 11;
   localparam int CSR_IDX_W = 2;

   // Default frame store limits.
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   // Smallest usable frame size, and the first row/column that closes a window.
   localparam int MIN_SIZE   = 3;
   localparam int FIRST_FULL = 2;

   // Register reset values.
   localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(480);

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_GRADIENT_MODE = CSR_IDX_W'(2);

   // Gradient mode codes.
   localparam logic MODE_GX = 1'b0;
   localparam logic MODE_GY = 1'b1;

   // Clamp ceiling of the result.
   localparam int GRAD_MAX = 255;

   // Entries in the queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

   // One classified window: positive and negative weighted triples already
   // chosen by the gradient mode, the centre position and the end-of-frame flag.
   typedef struct packed {
      logic [PIXEL_W-1:0] pos_a;
      logic [PIXEL_W-1:0] pos_b;
      logic [PIXEL_W-1:0] pos_c;
      logic [PIXEL_W-1:0] neg_a;
      logic [PIXEL_W-1:0] neg_b;
      logic [PIXEL_W-1:0] neg_c;
      logic [COORD_W-1:0] center_col;
      logic [COORD_W-1:0] center_row;
      logic               frame_last;
   } sgc_item_type;

endpackage

// ===== src/sgc_front.sv =====
// ----------------------------------------------------------------------------
// sgc_front: pixel intake, position tracking, line store and window
// Accepts pixels, tracks the raster position, reads and refreshes the line
// store and the 3x3 window, and pushes each interior window into the queue.
// ----------------------------------------------------------------------------
module sgc_front #(
   parameter int MAX_WIDTH  = sgc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = sgc_pkg::DEF_MAX_HEIGHT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [sgc_pkg::PIXEL_W-1:0]  req_pixel,
   input  logic                         req_frame_start,
   input  logic [sgc_pkg::SIZE_W-1:0]   image_width,
   input  logic [sgc_pkg::SIZE_W-1:0]   image_height,
   input  logic                         gradient_mode,
   input  logic [sgc_pkg::LEVEL_W-1:0]  queue_level,
   output logic                         push,
   output sgc_pkg::sgc_item_type        push_item
);
   import sgc_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int DIM_W = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                          $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
   localparam int CMP_W = ((DIM_W > SIZE_W) ? DIM_W : SIZE_W) + 1;

   // Line store entry holds the upper line over the middle line.
   logic [2*PIXEL_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIXEL_W-1:0] rd_data_ff;

   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               accept;

   logic [CMP_W-1:0]   width_reg, height_reg, width_eff, height_eff;
   logic [CMP_W-1:0]   col_a, row_a, col_b, row_b, row_c, col_n, row_n;
   logic [CMP_W-1:0]   col_dec, row_dec;

   // Second stage: waits for the line store read.
   logic               s1_valid_ff;
   logic               s1_produce_ff;
   logic               s1_last_ff;
   logic [COL_W-1:0]   s1_addr_ff;
   logic [PIXEL_W-1:0] s1_cur_ff;
   logic [COORD_W-1:0] s1_col_ff;
   logic [COORD_W-1:0] s1_row_ff;

   logic [PIXEL_W-1:0] win_ff [6];
   logic [PIXEL_W-1:0] up, mid;
   logic [LEVEL_W:0]   committed;

   // Keep room in the queue for every item that may still be pushed.
   assign committed = {1'b0, queue_level} + (LEVEL_W + 1)'(s1_valid_ff);
   assign req_stall = (committed >= (LEVEL_W + 1)'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   // Clamp the frame size registers to the usable range.
   always_comb begin
      width_reg  = CMP_W'(image_width);
      height_reg = CMP_W'(image_height);
      if (width_reg < CMP_W'(MIN_SIZE)) begin
         width_eff = CMP_W'(MIN_SIZE);
      end else if (width_reg > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = width_reg;
      end
      if (height_reg < CMP_W'(MIN_SIZE)) begin
         height_eff = CMP_W'(MIN_SIZE);
      end else if (height_reg > CMP_W'(MAX_HEIGHT)) begin
         height_eff = CMP_W'(MAX_HEIGHT);
      end else begin
         height_eff = height_reg;
      end
   end

   // Position of the incoming pixel and of the one after it.
   always_comb begin
      col_a = req_frame_start ? '0 : CMP_W'(col_ff);
      row_a = req_frame_start ? '0 : CMP_W'(row_ff);
      if (col_a >= width_eff) begin
         col_b = '0;
         row_b = row_a + CMP_W'(1);
      end else begin
         col_b = col_a;
         row_b = row_a;
      end
      row_c = (row_b >= height_eff) ? '0 : row_b;

      col_n = col_b + CMP_W'(1);
      row_n = row_c;
      if (col_n >= width_eff) begin
         col_n = '0;
         row_n = row_c + CMP_W'(1);
         if (row_n >= height_eff) begin
            row_n = '0;
         end
      end
      col_in  = col_n[COL_W-1:0];
      row_in  = row_n[ROW_W-1:0];
      col_dec = col_b - CMP_W'(1);
      row_dec = row_c - CMP_W'(1);
   end

   // Position counters advance on every transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line store read, registered.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= line_mem[col_b[COL_W-1:0]];
      end
   end

   // Line store write in the next cycle: the middle line moves up, the pixel in.
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         line_mem[s1_addr_ff] <= {mid, s1_cur_ff};
      end
   end

   // Second stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   // Second stage payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_produce_ff <= (row_c >= CMP_W'(FIRST_FULL)) && (col_b >= CMP_W'(FIRST_FULL));
         s1_last_ff    <= (row_c == height_eff - CMP_W'(1)) &&
                          (col_b == width_eff - CMP_W'(1));
         s1_addr_ff    <= col_b[COL_W-1:0];
         s1_cur_ff     <= req_pixel;
         s1_col_ff     <= col_dec[COORD_W-1:0];
         s1_row_ff     <= row_dec[COORD_W-1:0];
      end
   end

   assign up  = rd_data_ff[2*PIXEL_W-1:PIXEL_W];
   assign mid = rd_data_ff[PIXEL_W-1:0];

   // Window shift: slots 0..2 hold column c-1, slots 3..5 column c-2.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         win_ff[3] <= win_ff[0];
         win_ff[4] <= win_ff[1];
         win_ff[5] <= win_ff[2];
         win_ff[0] <= up;
         win_ff[1] <= mid;
         win_ff[2] <= s1_cur_ff;
      end
   end

   // Pick the two weighted triples for the selected gradient.
   always_comb begin
      push = s1_valid_ff && s1_produce_ff;
      if (gradient_mode == MODE_GY) begin
         push_item.pos_a = win_ff[3];
         push_item.pos_b = win_ff[0];
         push_item.pos_c = up;
         push_item.neg_a = win_ff[5];
         push_item.neg_b = win_ff[2];
         push_item.neg_c = s1_cur_ff;
      end else begin
         push_item.pos_a = up;
         push_item.pos_b = mid;
         push_item.pos_c = s1_cur_ff;
         push_item.neg_a = win_ff[3];
         push_item.neg_b = win_ff[4];
         push_item.neg_c = win_ff[5];
      end
      push_item.center_col = s1_col_ff;
      push_item.center_row = s1_row_ff;
      push_item.frame_last = s1_last_ff;
   end

endmodule

// ===== src/sgc_queue.sv =====
// ----------------------------------------------------------------------------
// sgc_queue: short queue between the front and back parts
// Holds classified windows so that intake and result delivery stall apart.
// ----------------------------------------------------------------------------
module sgc_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  sgc_pkg::sgc_item_type       push_item,
   input  logic                        pop,
   output sgc_pkg::sgc_item_type       head_item,
   output logic                        empty,
   output logic [sgc_pkg::LEVEL_W-1:0] level
);
   import sgc_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   sgc_item_type       slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_W-1:0] count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign level     = count_ff;
   assign head_item = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + LEVEL_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - LEVEL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/sgc_back.sv =====
// ----------------------------------------------------------------------------
// sgc_back: gradient evaluation and result register
// Weighs the two triples 1,2,1, subtracts, clamps to 0..255 and holds the
// result until the downstream side takes it.
// ----------------------------------------------------------------------------
module sgc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  sgc_pkg::sgc_item_type        head_item,
   input  logic                         empty,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [sgc_pkg::PIXEL_W-1:0]  rsp_gradient,
   output logic [sgc_pkg::COORD_W-1:0]  rsp_center_col,
   output logic [sgc_pkg::COORD_W-1:0]  rsp_center_row,
   output logic                         rsp_frame_last
);
   import sgc_pkg::*;

   localparam int SUM_W = PIXEL_W + 2;

   logic               valid_ff;
   logic [PIXEL_W-1:0] grad_ff, grad_in;
   logic [COORD_W-1:0] col_ff, row_ff;
   logic               last_ff;
   logic [SUM_W-1:0]   pos_sum, neg_sum;
   logic signed [SUM_W:0] diff;

   // Take a new item whenever the result register is free or being drained.
   assign pop = !empty && (!valid_ff || !rsp_stall);

   // Weighted sums, difference and clamp.
   always_comb begin
      pos_sum = SUM_W'(head_item.pos_a) + {1'b0, head_item.pos_b, 1'b0} +
                SUM_W'(head_item.pos_c);
      neg_sum = SUM_W'(head_item.neg_a) + {1'b0, head_item.neg_b, 1'b0} +
                SUM_W'(head_item.neg_c);
      diff    = $signed({1'b0, pos_sum}) - $signed({1'b0, neg_sum});
      if (diff < 0) begin
         grad_in = '0;
      end else if (diff > (SUM_W + 1)'(GRAD_MAX)) begin
         grad_in = PIXEL_W'(GRAD_MAX);
      end else begin
         grad_in = diff[PIXEL_W-1:0];
      end
   end

   // Result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (pop) begin
         grad_ff <= grad_in;
         col_ff  <= head_item.center_col;
         row_ff  <= head_item.center_row;
         last_ff <= head_item.frame_last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_gradient   = grad_ff;
   assign rsp_center_col = col_ff;
   assign rsp_center_row = row_ff;
   assign rsp_frame_last = last_ff;

endmodule

// ===== src/sobel_gradient_clamp_core.sv =====
// ----------------------------------------------------------------------------
// sobel_gradient_clamp_core: streaming 3x3 Sobel edge filter
// Raster-order grey pixels in, one clamped gx or gy gradient out for every
// interior pixel, with its centre position and an end-of-frame flag.
//
//   Channel  Direction  Handshake             Moves
//   req      in         req_valid/req_stall   pixel, frame_start
//   rsp      out        rsp_valid/rsp_stall   gradient, centre col/row, last
//   csr      in         csr_write             image_width/height, mode
//
// One pixel is taken per clock unless stalled; results pass the second stage,
// queue and output register. The line store is one memory with a registered
// read and a write in the next cycle; the front stalls once the queue entries
// plus the pixel waiting on the line store read reach four, the queue depth.
// A stalled result waits in the output register while intake goes on until
// the queue fills. Reset is synchronous; the line store has no clearing pass.
// ----------------------------------------------------------------------------
module sobel_gradient_clamp_core #(
   parameter int MAX_WIDTH  = sgc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = sgc_pkg::DEF_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [sgc_pkg::PIXEL_W-1:0]    req_pixel,
   input  logic                           req_frame_start,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sgc_pkg::PIXEL_W-1:0]    rsp_gradient,
   output logic [sgc_pkg::COORD_W-1:0]    rsp_center_col,
   output logic [sgc_pkg::COORD_W-1:0]    rsp_center_row,
   output logic                           rsp_frame_last,
   input  logic                           csr_write,
   input  logic [sgc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sgc_pkg::SIZE_W-1:0]     csr_data
);
   import sgc_pkg::*;

   logic [SIZE_W-1:0]  image_width_ff;
   logic [SIZE_W-1:0]  image_height_ff;
   logic               gradient_mode_ff;

   logic               push, pop, empty;
   sgc_item_type       push_item, head_item;
   logic [LEVEL_W-1:0] level;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= RESET_WIDTH;
         image_height_ff  <= RESET_HEIGHT;
         gradient_mode_ff <= MODE_GX;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:   image_width_ff   <= csr_data;
            REG_IMAGE_HEIGHT:  image_height_ff  <= csr_data;
            REG_GRADIENT_MODE: gradient_mode_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   sgc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .image_width     (image_width_ff),
      .image_height    (image_height_ff),
      .gradient_mode   (gradient_mode_ff),
      .queue_level     (level),
      .push            (push),
      .push_item       (push_item)
   );

   sgc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .empty     (empty),
      .level     (level)
   );

   sgc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_item      (head_item),
      .empty          (empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_gradient   (rsp_gradient),
      .rsp_center_col (rsp_center_col),
      .rsp_center_row (rsp_center_row),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

// ===== src/sgc_checker.sv =====
// ----------------------------------------------------------------------------
// sgc_checker: port-level checks for the Sobel gradient clamp core
// Watches the result channel for held transfers, interior positions and a
// clean start after reset.
// ----------------------------------------------------------------------------
module sgc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [sgc_pkg::PIXEL_W-1:0]   rsp_gradient,
   input logic [sgc_pkg::COORD_W-1:0]   rsp_center_col,
   input logic [sgc_pkg::COORD_W-1:0]   rsp_center_row,
   input logic                          rsp_frame_last
);
   import sgc_pkg::*;

   // A stalled result stays offered with the same contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_gradient) &&
      $stable(rsp_center_col) && $stable(rsp_center_row) && $stable(rsp_frame_last))
      else $error("result changed while stalled");

   // Results never carry a centre in row or column zero.
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_center_col != '0) && (rsp_center_row != '0))
      else $error("result for a border position");

   // Reset empties the output register.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind sobel_gradient_clamp_core sgc_checker u_sgc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_gradient   (rsp_gradient),
   .rsp_center_col (rsp_center_col),
   .rsp_center_row (rsp_center_row),
   .rsp_frame_last (rsp_frame_last)
);
